// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// Checked outside reset only.
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Types, register codes and signed-magnitude helpers of the projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PIX_W    = 16;
  localparam logic [15:0] MIN_RATIO = 16'd16;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_SINE     = 3'd2,
    REG_COSINE   = 3'd3,
    REG_SCALE    = 3'd4,
    REG_FOCAL    = 3'd5,
    REG_TILE     = 3'd6,
    REG_CENTER   = 3'd7
  } reg_index_t;

  function automatic logic [31:0] sm_to_twos(input logic [31:0] v);
    return v[31] ? (32'd0 - {1'b0, v[30:0]}) : v;
  endfunction

  // Signed-magnitude add; a negative sum comes back as sign + magnitude.
  function automatic logic [31:0] sm_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = sm_to_twos(a) + sm_to_twos(b);
    return s[31] ? (32'd0 - {1'b0, s[30:0]}) : s;
  endfunction

  // magnitude(a) * frac(b) >> 16, sign is the XOR of both signs
  function automatic logic [31:0] sm_mul_frac(input logic [31:0] a, input logic [31:0] b);
    logic [46:0] p;
    p = {16'd0, a[30:0]} * {31'd0, b[15:0]};
    return {a[31] ^ b[31], p[46:16]};
  endfunction

endpackage

// ----- hw/rtl/ppp_div.sv -----
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int unsigned N     = 32,
  parameter int unsigned D     = 31,
  parameter int unsigned LANES = 1,
  parameter int unsigned W     = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][N-1:0]     dividend,
  input  logic [D-1:0]                divisor,
  input  logic [W-1:0]                side,
  output logic                        out_valid,
  output logic [LANES-1:0][N-1:0]     quotient,
  output logic [W-1:0]                side_out
);

  logic [LANES-1:0][D-1:0] rem  [0:N];
  logic [LANES-1:0][N-1:0] num  [0:N];
  logic [D-1:0]            dv   [0:N];
  logic [W-1:0]            sd   [0:N];
  logic                    vld  [0:N];

  assign rem[0] = '0;
  assign num[0] = dividend;
  assign dv[0]  = divisor;
  assign sd[0]  = side;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [LANES-1:0][D-1:0] rem_next;
    logic [LANES-1:0][N-1:0] num_next;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [D:0] t;
      logic       ge;
      logic [D:0] diff;
      assign t    = {rem[k][l], num[k][l][N-1]};
      assign ge   = t >= {1'b0, dv[k]};
      assign diff = t - {1'b0, dv[k]};
      assign rem_next[l] = ge ? diff[D-1:0] : t[D-1:0];
      assign num_next[l] = {num[k][l][N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rem_next;
        num[k+1] <= num_next;
        dv[k+1]  <= dv[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign quotient  = num[N];
  assign side_out  = sd[N];

endmodule

// ----- hw/rtl/ppp_rotate.sv -----
// ----------------------------------------------------------------------------
// ppp_rotate
// Three stages: origin subtract, fraction multiplies, rotated sums.
// ----------------------------------------------------------------------------
module ppp_rotate import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] view_origin_x,
  input  logic [31:0] view_origin_y,
  input  logic [31:0] view_sine,
  input  logic [31:0] view_cosine,
  output logic        out_valid,
  output logic [31:0] nx,
  output logic [31:0] ny
);

  logic        v1, v2;
  logic [31:0] gx, gy;
  logic [31:0] mxc, mys, myc, mxs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx  <= sm_add(point_x, view_origin_x | 32'h8000_0000);
      gy  <= sm_add(point_y, view_origin_y | 32'h8000_0000);
      mxc <= sm_mul_frac(gx, view_cosine);
      mys <= sm_mul_frac(gy, view_sine);
      myc <= sm_mul_frac(gy, view_cosine);
      mxs <= sm_mul_frac(gx, view_sine);
      nx  <= sm_add(mxc, mys ^ 32'h8000_0000);
      ny  <= sm_add(myc, mxs);
    end
  end

endmodule

// ----- hw/rtl/perspective_point_projection.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projection
// Rotates a world point into view space and projects it to a screen column
// and height.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | point_x, point_y
//  out     | out_valid / out_stall| depth, screen_column, screen_height
//  cfg     | cfg_write            | cfg_index, cfg_data
//
//  One point per cycle while out is not stalled; stages: 3 rotate, product,
//  32-stage ratio divider, ratio, 31-stage column/height divider, output.
//  Reset clears all valid bits and loads the register defaults.
//  A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module perspective_point_projection import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] depth,
  output logic signed [15:0] screen_column,
  output logic [15:0] screen_height,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] view_origin_x, view_origin_y, view_sine, view_cosine;
  logic [30:0] projection_scale, focal_length, tile_size_global;
  logic [15:0] screen_center_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_origin_x    <= 32'd0;
      view_origin_y    <= 32'd0;
      view_sine        <= 32'd0;
      view_cosine      <= 32'd65535;
      projection_scale <= 31'd256;
      focal_length     <= 31'd65536;
      tile_size_global <= 31'd65536;
      screen_center_x  <= 16'd160;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X: view_origin_x    <= cfg_data;
        REG_ORIGIN_Y: view_origin_y    <= cfg_data;
        REG_SINE:     view_sine        <= cfg_data;
        REG_COSINE:   view_cosine      <= cfg_data;
        REG_SCALE:    projection_scale <= cfg_data[30:0];
        REG_FOCAL:    focal_length     <= cfg_data[30:0];
        REG_TILE:     tile_size_global <= cfg_data[30:0];
        REG_CENTER:   screen_center_x  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // rotate
  logic        rv;
  logic [31:0] nx, ny;

  ppp_rotate u_rotate (
    .clk, .rst, .en, .in_valid, .point_x, .point_y,
    .view_origin_x, .view_origin_y, .view_sine, .view_cosine,
    .out_valid(rv), .nx, .ny
  );

  // depth * scale, wrapping
  logic        v4;
  logic [31:0] prod, nx4, ny4;
  logic [31:0] dpos;
  assign dpos = nx[31] ? 32'd0 : nx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= dpos * {1'b0, projection_scale};
      nx4  <= nx;
      ny4  <= ny;
    end
  end

  logic        neg;
  logic [31:0] mag;
  logic [30:0] fdiv;
  assign neg  = prod[31];
  assign mag  = neg ? (32'd0 - prod) : prod;
  assign fdiv = (focal_length == 31'd0) ? 31'd1 : focal_length;

  logic              dv1;
  logic [0:0][31:0]  q1;
  logic [64:0]       s1;

  ppp_div #(.N(32), .D(31), .LANES(1), .W(65)) u_ratio_div (
    .clk, .rst, .en,
    .in_valid(v4),
    .dividend(mag),
    .divisor(fdiv),
    .side({neg, nx4, ny4}),
    .out_valid(dv1),
    .quotient(q1),
    .side_out(s1)
  );

  // ratio clamp
  logic [31:0] qs;
  logic [15:0] ratio_next;
  assign qs = s1[64] ? (32'd0 - q1[0]) : q1[0];
  assign ratio_next = (qs[15] || qs[15:0] <= MIN_RATIO) ? MIN_RATIO : qs[15:0];

  logic        v6;
  logic [15:0] ratio;
  logic [31:0] nx6, ny6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= dv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio <= ratio_next;
      nx6   <= s1[63:32];
      ny6   <= s1[31:0];
    end
  end

  logic             dv2;
  logic [1:0][30:0] q2;
  logic [32:0]      s2;

  ppp_div #(.N(31), .D(16), .LANES(2), .W(33)) u_screen_div (
    .clk, .rst, .en,
    .in_valid(v6),
    .dividend({tile_size_global, ny6[30:0]}),
    .divisor(ratio),
    .side({nx6, ny6[31]}),
    .out_valid(dv2),
    .quotient(q2),
    .side_out(s2)
  );

  logic [15:0] col_next;
  assign col_next = s2[0] ? (screen_center_x - q2[0][15:0])
                          : (screen_center_x + q2[0][15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth         <= s2[32:1];
      screen_column <= col_next;
      screen_height <= q2[1][15:0];
    end
  end

endmodule

// ----- hw/rtl/ppp_checker.sv -----
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] depth
);

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `ASSERT_RUN(a_stall_only_if_full, clk, rst, in_stall |-> (out_valid && out_stall))
  `ASSERT_RUN(a_valid_holds, clk, rst, (out_valid && out_stall) |=> out_valid)
  `ASSERT_RUN(a_depth_holds, clk, rst, (out_valid && out_stall) |=> $stable(depth))

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .depth
);

// ----- bench/ppp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_scoreboard
// Watches the point and result channels and the register port of the
// projection block, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module ppp_scoreboard import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] depth,
  input  logic signed [15:0] screen_column,
  input  logic [15:0] screen_height,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] depth;
    logic [15:0] column;
    logic [15:0] height;
  } projection_t;

  logic [31:0] org_x, org_y, sine, cosine, scale, focal, tile;
  logic [15:0] center;
  projection_t projections[$];

  function automatic logic [31:0] to_twos(input logic [31:0] v);
    return v[31] ? -{1'b0, v[30:0]} : v;
  endfunction

  function automatic logic [31:0] smag_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] s;
    s = to_twos(a) + to_twos(b);
    return s[31] ? -{1'b0, s[30:0]} : s;
  endfunction

  function automatic logic [31:0] frac_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a[30:0]) * 64'(b[15:0]);
    return {a[31] ^ b[31], p[46:16]};
  endfunction

  function automatic projection_t project(input logic [31:0] px, input logic [31:0] py);
    logic [31:0] gx, gy, nx, ny, dpos, prod, mag, q, f, ratio, col;
    logic [31:0] ctr;
    projection_t r;
    gx = smag_sum(px, org_x | 32'h8000_0000);
    gy = smag_sum(py, org_y | 32'h8000_0000);
    nx = smag_sum(frac_mul(gx, cosine), frac_mul(gy, sine) ^ 32'h8000_0000);
    ny = smag_sum(frac_mul(gy, cosine), frac_mul(gx, sine));
    dpos = nx[31] ? 32'd0 : nx;
    prod = dpos * scale;
    mag = prod[31] ? -prod : prod;
    f = (focal == 0) ? 32'd1 : focal;
    q = mag / f;
    if (prod[31]) q = -q;
    ratio = (q[15] || q[15:0] <= MIN_RATIO) ? 32'(MIN_RATIO) : {16'd0, q[15:0]};
    ctr = {{16{center[15]}}, center};
    if (ny[31]) col = ctr - ({1'b0, ny[30:0]} / ratio);
    else col = ctr + (ny / ratio);
    r.depth = nx;
    r.column = col[15:0];
    r.height = 16'(tile / ratio);
    return r;
  endfunction

  always @(posedge clk) begin
    projection_t want;
    if (rst) begin
      org_x <= 0; org_y <= 0; sine <= 0; cosine <= 32'd65535;
      scale <= 256; focal <= 65536; tile <= 65536; center <= 16'd160;
      projections.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_ORIGIN_X: org_x <= cfg_data;
          REG_ORIGIN_Y: org_y <= cfg_data;
          REG_SINE:     sine <= cfg_data;
          REG_COSINE:   cosine <= cfg_data;
          REG_SCALE:    scale <= {1'b0, cfg_data[30:0]};
          REG_FOCAL:    focal <= {1'b0, cfg_data[30:0]};
          REG_TILE:     tile <= {1'b0, cfg_data[30:0]};
          REG_CENTER:   center <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) projections.push_back(project(point_x, point_y));
      if (out_valid && !out_stall) begin
        if (projections.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = projections.pop_front();
          if (want.depth !== depth || want.column !== screen_column ||
              want.height !== screen_height) begin
            if (fail_count < 10)
              $display("mismatch: exp %h %h %h got %h %h %h", want.depth, want.column,
                       want.height, depth, screen_column, screen_height);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= projections.size();
    end
  end

endmodule

// ----- bench/tb_perspective_point_projection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perspective_point_projection
// Drives points with random idling and register settings through the
// projection block; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_perspective_point_projection import ppp_pkg::*;;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, cfg_write = 0;
  logic [31:0] point_x = 0, point_y = 0, cfg_data = 0;
  logic [2:0] cfg_index = 0;
  logic in_stall, out_valid;
  logic [31:0] depth;
  logic signed [15:0] screen_column;
  logic [15:0] screen_height;
  int fail_count, pending;
  bit quiet = 0, hold_long = 0;

  always #6 clk = ~clk;

  perspective_point_projection uut (.*);
  ppp_scoreboard chk (.*);

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic [31:0] rand_sm();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h00ff_ffff))};
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [31:0] x, input logic [31:0] y);
    in_valid <= 1; point_x <= x; point_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_gap();
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // leaves cfg_write high; the caller drops it after the last write
  task automatic write_reg(input reg_index_t idx, input logic [31:0] v);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_config(input int mode);
    write_reg(REG_ORIGIN_X, mode == 0 ? 32'hffff_ffff : rand_sm());
    write_reg(REG_ORIGIN_Y, mode == 0 ? 32'h7fff_ffff : rand_sm());
    write_reg(REG_SINE, $urandom);
    write_reg(REG_COSINE, $urandom);
    write_reg(REG_SCALE, mode == 0 ? 32'h7fff_ffff : $urandom_range(0, 4096));
    write_reg(REG_FOCAL, mode == 0 ? 32'd0 : (mode == 1 ? 32'd1 : $urandom));
    write_reg(REG_TILE, mode == 0 ? 32'h7fff_ffff : $urandom);
    write_reg(REG_CENTER, mode == 0 ? 32'h8000 : (mode == 1 ? 32'h7fff : $urandom));
    cfg_write <= 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed points at reset settings: zeros, negative zero, extremes
    send(0, 0); send(32'h8000_0000, 32'h8000_0000);
    send(32'h7fff_ffff, 0); send(32'hffff_ffff, 0);
    send(0, 32'h7fff_ffff); send(0, 32'hffff_ffff);
    send(32'h0010_0000, 32'h8005_0000); send(32'h0000_0010, 32'h0001_0000);
    send(32'h7fff_ffff, 32'hffff_ffff); send(32'h0001_0000, 32'h0001_0000);
    drain();
    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase);
      if (phase == 3) hold_long = 1;
      if (phase == 7) quiet = 1;
      for (int i = 0; i < 192; i++) begin
        send(rand_sm(), rand_sm());
        maybe_gap();
      end
      drain();
    end
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
